// ===== src/kademlia_bucket_replacement_core_assert.svh =====
// Assertion macros shared by the bucket replacement core.
`ifndef KADEMLIA_BUCKET_REPLACEMENT_CORE_ASSERT_SVH
`define KADEMLIA_BUCKET_REPLACEMENT_CORE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define KBR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define KBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define KBR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/kbr_pkg.sv =====
// Types and codes shared by the contact bucket core.
package kbr_pkg;

	typedef struct packed {
		logic [63:0] id_high;
		logic [63:0] id_middle;
		logic [31:0] id_low;
		logic [31:0] ip;
		logic [15:0] port;
	} contact_t;

	typedef struct packed {
		contact_t    c;
		logic [31:0] seen;
		logic [1:0]  fails;
		logic [1:0]  pings;
	} entry_t;

	localparam logic [1:0] OP_INSERT       = 2'd0;
	localparam logic [1:0] OP_PING_RESP    = 2'd1;
	localparam logic [1:0] OP_PING_TIMEOUT = 2'd2;
	localparam logic [1:0] OP_REQ_TIMEOUT  = 2'd3;

	localparam logic [2:0] ST_REFRESHED = 3'd0;
	localparam logic [2:0] ST_ADDED     = 3'd1;
	localparam logic [2:0] ST_REPLACED  = 3'd2;
	localparam logic [2:0] ST_PINGED    = 3'd3;
	localparam logic [2:0] ST_QUEUED    = 3'd4;
	localparam logic [2:0] ST_DROPPED   = 3'd5;
	localparam logic [2:0] ST_BAD_TAG   = 3'd6;
	localparam logic [2:0] ST_NOTHING   = 3'd7;

	localparam logic [1:0] CFG_GOOD_WINDOW = 2'd0;
	localparam logic [1:0] CFG_BAD_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_PING_SLOTS  = 2'd2;
	localparam logic [1:0] CFG_STALE       = 2'd3;

	localparam logic [31:0] RST_WINDOW_MS = 32'd900000;
	localparam logic [1:0]  RST_BAD_LIMIT = 2'd2;
	localparam logic [1:0]  RST_SLOTS     = 2'd2;

endpackage

// ===== src/kademlia_bucket_replacement_core.sv =====
// Top level of the contact bucket core with replacement queue and ping slots.
//
// A command beat is taken when start is high and busy is low; busy then stays
// high until the result is shown. The result is on the output ports for one
// cycle, marked by done, and the receiver cannot stall it.
// Entries live in one RAM indexed by physical slot; an age-order register maps
// each position to its slot. Each command but a tag miss scans the valid
// entries through the RAM read port, one per cycle, then decides and writes
// back at most one entry per scan. A ping timeout that restarts a waiting
// contact scans twice; a tag miss skips the scan. Commands are taken one at a
// time; the next one may be taken in the cycle in which done is high.
// Waiting contacts sit in a small RAM FIFO, read at its head.
// Configuration writes through cfg_we, cfg_index and cfg_wdata take effect at
// once; the user must make them only while the core is idle, as the core does
// not enforce it. Reset empties the bucket, frees both ping slots, empties the
// queue and loads the register defaults; no clearing pass is needed.
`include "kademlia_bucket_replacement_core_assert.svh"

module kademlia_bucket_replacement_core #(
	parameter int BUCKET_SIZE = 8,
	parameter int WAIT_DEPTH  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  operation,
	input  logic [63:0] id_high,
	input  logic [63:0] id_middle,
	input  logic [31:0] id_low,
	input  logic [31:0] ip_addr,
	input  logic [15:0] udp_port,
	input  logic        call_tag,
	input  logic [31:0] now_ms,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output logic [2:0]  status,
	output logic        ping_valid,
	output logic        ping_tag,
	output logic [31:0] ping_ip,
	output logic [15:0] ping_port,
	output logic [$clog2(BUCKET_SIZE+1)-1:0] entry_count,
	output logic        found_flag,
	output logic        bucket_stale
);

	import kbr_pkg::*;

	localparam int CW  = $clog2(BUCKET_SIZE + 1);
	localparam int PW  = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
	localparam int QCW = $clog2(WAIT_DEPTH + 1);
	localparam int QHW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam logic [CW-1:0]  FULL_CNT = CW'(BUCKET_SIZE);
	localparam logic [QCW-1:0] Q_FULL   = QCW'(WAIT_DEPTH);
	localparam logic [QCW:0]   Q_DEPTH  = (QCW+1)'(WAIT_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_FIN} state_t;
	typedef enum logic [1:0] {ACT_NONE, ACT_ROT, ACT_APPEND, ACT_WB} act_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] good_q, stale_q;
	logic [1:0]  blim_q, slots_q;

	// Bucket bookkeeping.
	logic [PW-1:0]  order_q [BUCKET_SIZE];
	logic [CW-1:0]  count_q;
	logic [31:0]    lc_q;
	logic [1:0]     pbusy_q;
	logic [31:0]    tgt_ip_q   [2];
	logic [15:0]    tgt_port_q [2];
	contact_t       held_q     [2];
	logic [QCW-1:0] wc_q;
	logic [QHW-1:0] wh_q;

	// Command context.
	logic [1:0]  op_q;
	logic        tag_q;
	logic [31:0] now_q;
	logic [31:0] key_ip_q;
	logic [15:0] key_port_q;
	contact_t    cur_q;
	logic        pass2_q;

	// Scan pointers and first hits.
	logic [CW-1:0] rpos_q;
	logic          vld_s1;
	logic [PW-1:0] pos_s1, ph_s1;
	logic          idf_q, af_q, bf_q, qf_q;
	logic [PW-1:0] idpos_q, idph_q, apos_q, aph_q, bpos_q, bph_q, qph_q;
	entry_t        aword_q, qword_q;

	// Result registers.
	logic [2:0]  status_q;
	logic        done_q, found_q, pv_q, ptag_q, stale_out_q;
	logic [31:0] pip_q;
	logic [15:0] pport_q;

	// RAM ports.
	logic          slot_we;
	logic [PW-1:0] slot_waddr, slot_raddr;
	entry_t        slot_wdata, slot_rdata;
	logic          q_we;
	logic [QHW-1:0] q_waddr;
	contact_t      q_rdata;

	kbr_ram #(.WIDTH($bits(entry_t)), .DEPTH(BUCKET_SIZE)) u_slots (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	kbr_ram #(.WIDTH($bits(contact_t)), .DEPTH(WAIT_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(cur_q),
		.raddr(wh_q), .rdata(q_rdata)
	);

	// Classification of the entry coming out of the RAM.
	logic [31:0] age;
	logic        is_q, is_bad, id_eq, addr_eq;
	always_comb begin
		age     = now_q - slot_rdata.seen;
		is_q    = age > good_q;
		is_bad  = is_q && (slot_rdata.fails > blim_q || slot_rdata.pings > blim_q);
		addr_eq = slot_rdata.c.ip == key_ip_q && slot_rdata.c.port == key_port_q;
		id_eq   = slot_rdata.c == cur_q;
	end

	// Queue tail position, wrapping at the queue depth.
	logic [QCW:0] tsum;
	always_comb begin
		tsum = (QCW+1)'(wh_q) + (QCW+1)'(wc_q);
		if (tsum >= Q_DEPTH) begin
			tsum = tsum - Q_DEPTH;
		end
		q_waddr = tsum[QHW-1:0];
	end

	// Decision taken once the scan is over.
	act_t          act;
	logic [PW-1:0] act_pos, act_ph;
	entry_t        wword, newe;
	logic [2:0]    nstat;
	logic          set_lc, do_ping, ptag_n, do_enq, do_pass2, set_found, do_free;
	logic [1:0]    pb_eff, pb_after;
	logic          lim2, slots_full;

	always_comb begin
		act       = ACT_NONE;
		act_pos   = '0;
		act_ph    = '0;
		nstat     = status_q;
		set_lc    = 1'b0;
		do_ping   = 1'b0;
		ptag_n    = 1'b0;
		do_enq    = 1'b0;
		do_pass2  = 1'b0;
		set_found = 1'b0;
		do_free   = 1'b0;
		newe      = '{c: cur_q, seen: now_q, fails: 2'd0, pings: 2'd0};
		wword     = newe;
		lim2      = slots_q[1];
		pb_after  = pbusy_q & ~(2'b01 << tag_q);
		pb_eff    = (op_q == OP_PING_TIMEOUT && !pass2_q) ? pb_after : pbusy_q;
		slots_full = lim2 ? (pb_eff[0] & pb_eff[1]) : (pb_eff[0] | pb_eff[1]);

		if (op_q == OP_INSERT && idf_q) begin
			act = ACT_ROT; act_pos = idpos_q; act_ph = idph_q;
			set_lc = 1'b1; nstat = ST_REFRESHED;
		end else if (op_q == OP_INSERT && count_q < FULL_CNT) begin
			act = ACT_APPEND; set_lc = 1'b1; nstat = ST_ADDED;
		end else if (op_q == OP_REQ_TIMEOUT) begin
			nstat = ST_NOTHING;
			if (af_q) begin
				act = ACT_WB; act_ph = aph_q;
				wword = aword_q;
				wword.fails = (aword_q.fails == 2'd3) ? 2'd3 : aword_q.fails + 2'd1;
				set_found = 1'b1;
			end
		end else if (op_q == OP_PING_TIMEOUT && !pass2_q) begin
			do_free = 1'b1;
			nstat = ST_NOTHING;
			if (af_q) begin
				act = ACT_ROT; act_pos = apos_q; act_ph = aph_q;
				set_lc = 1'b1; nstat = ST_REPLACED;
			end
			if (!slots_full && wc_q != '0) begin
				do_pass2 = 1'b1;
			end
		end else begin
			// Placement: replace a bad entry, else queue or drop when the ping slots are full, else ping a questionable one.
			if (bf_q) begin
				act = ACT_ROT; act_pos = bpos_q; act_ph = bph_q;
				set_lc = 1'b1; nstat = ST_REPLACED;
			end else if (slots_full) begin
				if (wc_q >= Q_FULL) begin
					nstat = ST_DROPPED;
				end else begin
					do_enq = 1'b1; nstat = ST_QUEUED;
				end
			end else if (qf_q) begin
				do_ping = 1'b1;
				ptag_n = pb_eff[0];
				act = ACT_WB; act_ph = qph_q;
				wword = qword_q;
				wword.pings = (qword_q.pings == 2'd3) ? 2'd3 : qword_q.pings + 2'd1;
				nstat = ST_PINGED;
			end else begin
				nstat = ST_DROPPED;
			end
		end
	end

	// RAM port drive.
	always_comb begin
		slot_raddr = order_q[rpos_q[PW-1:0]];
		slot_we    = state_q == S_DECIDE && act != ACT_NONE;
		slot_waddr = (act == ACT_APPEND) ? order_q[count_q[PW-1:0]] : act_ph;
		slot_wdata = wword;
		q_we       = state_q == S_DECIDE && do_enq;
	end

	// Sequencer, bookkeeping and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			good_q  <= RST_WINDOW_MS;
			stale_q <= RST_WINDOW_MS;
			blim_q  <= RST_BAD_LIMIT;
			slots_q <= RST_SLOTS;
			for (int k = 0; k < BUCKET_SIZE; k++) begin
				order_q[k] <= PW'(k);
			end
			count_q <= '0;
			lc_q    <= '0;
			pbusy_q <= '0;
			wc_q    <= '0;
			wh_q    <= '0;
			rpos_q  <= '0;
			vld_s1  <= 1'b0;
			pass2_q <= 1'b0;
			done_q  <= 1'b0;
			idf_q   <= 1'b0;
			af_q    <= 1'b0;
			bf_q    <= 1'b0;
			qf_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Configuration writes.
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GOOD_WINDOW: good_q  <= cfg_wdata;
					CFG_BAD_LIMIT:   blim_q  <= cfg_wdata[1:0];
					CFG_PING_SLOTS:  slots_q <= cfg_wdata[1:0];
					CFG_STALE:       stale_q <= cfg_wdata;
					default: ;
				endcase
			end

			// First hits of the scan, one entry a cycle.
			if (vld_s1) begin
				if (!idf_q && id_eq) begin
					idf_q <= 1'b1; idpos_q <= pos_s1; idph_q <= ph_s1;
				end
				if (!af_q && addr_eq) begin
					af_q <= 1'b1; apos_q <= pos_s1; aph_q <= ph_s1; aword_q <= slot_rdata;
				end
				if (!bf_q && is_bad) begin
					bf_q <= 1'b1; bpos_q <= pos_s1; bph_q <= ph_s1;
				end
				if (!qf_q && is_q) begin
					qf_q <= 1'b1; qph_q <= ph_s1; qword_q <= slot_rdata;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						tag_q   <= call_tag;
						now_q   <= now_ms;
						pass2_q <= 1'b0;
						pv_q    <= 1'b0;
						ptag_q  <= 1'b0;
						pip_q   <= '0;
						pport_q <= '0;
						found_q <= 1'b0;
						rpos_q  <= '0;
						idf_q   <= 1'b0;
						af_q    <= 1'b0;
						bf_q    <= 1'b0;
						qf_q    <= 1'b0;
						if (operation == OP_INSERT || operation == OP_REQ_TIMEOUT) begin
							cur_q      <= '{id_high, id_middle, id_low, ip_addr, udp_port};
							key_ip_q   <= ip_addr;
							key_port_q <= udp_port;
						end else begin
							cur_q      <= held_q[call_tag];
							key_ip_q   <= tgt_ip_q[call_tag];
							key_port_q <= tgt_port_q[call_tag];
						end
						if (operation == OP_PING_RESP) begin
							lc_q <= now_ms;
						end
						if ((operation == OP_PING_RESP || operation == OP_PING_TIMEOUT)
						    && !pbusy_q[call_tag]) begin
							status_q <= ST_BAD_TAG;
							state_q  <= S_FIN;
						end else begin
							if (operation == OP_PING_RESP) begin
								pbusy_q[call_tag] <= 1'b0;
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rpos_q < count_q) begin
						vld_s1 <= 1'b1;
						pos_s1 <= rpos_q[PW-1:0];
						ph_s1  <= slot_raddr;
						rpos_q <= rpos_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					status_q <= nstat;
					if (set_lc) begin
						lc_q <= now_q;
					end
					if (set_found) begin
						found_q <= 1'b1;
					end
					// Age order: rotate the removed slot to the newest position.
					if (act == ACT_ROT) begin
						for (int k = 0; k < BUCKET_SIZE; k++) begin
							if (CW'(k) >= CW'(act_pos) && CW'(k) + CW'(1) < count_q) begin
								order_q[k] <= order_q[(k + 1) % BUCKET_SIZE];
							end
							if (CW'(k) + CW'(1) == count_q) begin
								order_q[k] <= act_ph;
							end
						end
					end
					if (act == ACT_APPEND) begin
						count_q <= count_q + CW'(1);
					end
					if (do_ping) begin
						pbusy_q[ptag_n]    <= 1'b1;
						tgt_ip_q[ptag_n]   <= qword_q.c.ip;
						tgt_port_q[ptag_n] <= qword_q.c.port;
						held_q[ptag_n]     <= cur_q;
						pv_q    <= 1'b1;
						ptag_q  <= ptag_n;
						pip_q   <= qword_q.c.ip;
						pport_q <= qword_q.c.port;
					end
					if (do_free) begin
						pbusy_q[tag_q] <= 1'b0;
					end
					if (do_enq) begin
						wc_q <= wc_q + QCW'(1);
					end
					if (do_pass2) begin
						// Restart the oldest waiting contact with a fresh scan.
						cur_q   <= q_rdata;
						wh_q    <= (QCW'(wh_q) + QCW'(1) == Q_FULL) ? '0 : wh_q + QHW'(1);
						wc_q    <= wc_q - QCW'(1);
						pass2_q <= 1'b1;
						rpos_q  <= '0;
						idf_q   <= 1'b0;
						af_q    <= 1'b0;
						bf_q    <= 1'b0;
						qf_q    <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q      <= 1'b1;
					stale_out_q <= count_q != '0 && (now_q - lc_q) > stale_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign ping_valid   = pv_q;
	assign ping_tag     = ptag_q;
	assign ping_ip      = pip_q;
	assign ping_port    = pport_q;
	assign entry_count  = count_q;
	assign found_flag   = found_q;
	assign bucket_stale = stale_out_q;

	`KBR_ASSERT_ALWAYS(a_count_range, count_q <= FULL_CNT, "entry count beyond bucket size")
	`KBR_ASSERT_ALWAYS(a_queue_range, wc_q <= Q_FULL, "wait count beyond queue depth")
	`KBR_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done lasted more than one cycle")
	`KBR_ASSERT_SAME(a_ping_busy, done_q && pv_q, pbusy_q[ptag_q], "ping issued on a free slot")

endmodule

// ===== src/kbr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module kbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the contact bucket core with its ping slots and wait queue.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kbr_pkg::*;

	localparam int SLOTS    = 8;
	localparam int QDEPTH   = 4;
	localparam int PHASES   = 6;
	localparam int PER_PHASE = 320;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [1:0]  op;
		contact_t    c;
		logic        tag;
		logic [31:0] now;
	} cmd_t;

	typedef struct {
		logic [2:0]  status;
		logic        pv;
		logic        ptag;
		logic [31:0] pip;
		logic [15:0] pport;
		logic [3:0]  cnt;
		logic        found;
		logic        stale;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start;
	logic busy, done;
	logic [1:0]  operation;
	logic [63:0] id_high, id_middle;
	logic [31:0] id_low, ip_addr, now_ms;
	logic [15:0] udp_port;
	logic        call_tag;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_GOOD_WINDOW;
	logic [31:0] cfg_wdata = '0;
	logic [2:0]  status;
	logic        ping_valid, ping_tag;
	logic [31:0] ping_ip;
	logic [15:0] ping_port;
	logic [3:0]  entry_count;
	logic        found_flag, bucket_stale;

	kademlia_bucket_replacement_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.operation(operation), .id_high(id_high), .id_middle(id_middle),
		.id_low(id_low), .ip_addr(ip_addr), .udp_port(udp_port),
		.call_tag(call_tag), .now_ms(now_ms), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .status(status),
		.ping_valid(ping_valid), .ping_tag(ping_tag), .ping_ip(ping_ip),
		.ping_port(ping_port), .entry_count(entry_count),
		.found_flag(found_flag), .bucket_stale(bucket_stale)
	);

	always #5 clk = ~clk;

	// Mirror of the bucket state and registers.
	logic        bk_valid [SLOTS];
	contact_t    bk_c     [SLOTS];
	logic [31:0] bk_seen  [SLOTS];
	logic [1:0]  bk_fail  [SLOTS];
	logic [1:0]  bk_ping  [SLOTS];
	logic        tag_busy [2];
	logic [31:0] tgt_ip   [2];
	logic [15:0] tgt_port [2];
	contact_t    held     [2];
	contact_t    waitq    [QDEPTH];
	int          wait_cnt, wait_hd;
	logic [31:0] last_chg;
	logic [31:0] m_window = RST_WINDOW_MS;
	logic [1:0]  m_bad    = RST_BAD_LIMIT;
	logic [1:0]  m_slots  = RST_SLOTS;
	logic [31:0] m_stale  = 32'd900000;
	outcome_t    res;

	cmd_t     pending_cmds [$];
	outcome_t expected_results [$];
	int idle_pct = 9;
	int err_count = 0;
	int accepted = 0;
	int checked = 0;
	int pings_seen = 0;

	function automatic int live_count();
		int n;
		n = 0;
		while (n < SLOTS && bk_valid[n]) n++;
		return n;
	endfunction

	function automatic void drop_pos(int p);
		int n;
		n = live_count();
		if (p >= n) return;
		for (int k = p; k + 1 < n; k++) begin
			bk_valid[k] = bk_valid[k+1];
			bk_c[k]     = bk_c[k+1];
			bk_seen[k]  = bk_seen[k+1];
			bk_fail[k]  = bk_fail[k+1];
			bk_ping[k]  = bk_ping[k+1];
		end
		bk_valid[n-1] = 1'b0;
	endfunction

	function automatic void push_newest(contact_t c, logic [31:0] now);
		int n;
		n = live_count();
		if (n >= SLOTS) return;
		bk_valid[n] = 1'b1;
		bk_c[n]     = c;
		bk_seen[n]  = now;
		bk_fail[n]  = 2'd0;
		bk_ping[n]  = 2'd0;
	endfunction

	function automatic bit is_aged(int p, logic [31:0] now);
		logic [31:0] d;
		d = now - bk_seen[p];
		return d > m_window;
	endfunction

	function automatic bit is_bad(int p, logic [31:0] now);
		return is_aged(p, now) && (bk_fail[p] > m_bad || bk_ping[p] > m_bad);
	endfunction

	function automatic int usable_tags();
		if (m_slots == 2'd0) return 1;
		return (m_slots > 2'd2) ? 2 : int'(m_slots);
	endfunction

	function automatic int busy_tags();
		return int'(tag_busy[0]) + int'(tag_busy[1]);
	endfunction

	// Place a contact in a full bucket: evict a bad entry, ping, queue or drop.
	function automatic logic [2:0] place_contact(contact_t c, logic [31:0] now);
		int n, lim, t;
		n = live_count();
		lim = usable_tags();
		for (int p = 0; p < n; p++) begin
			if (is_bad(p, now)) begin
				drop_pos(p);
				push_newest(c, now);
				last_chg = now;
				return ST_REPLACED;
			end
		end
		if (busy_tags() >= lim) begin
			if (wait_cnt >= QDEPTH) return ST_DROPPED;
			waitq[(wait_hd + wait_cnt) % QDEPTH] = c;
			wait_cnt++;
			return ST_QUEUED;
		end
		for (int p = 0; p < n; p++) begin
			if (!is_aged(p, now)) continue;
			for (t = 0; t < lim; t++) if (!tag_busy[t]) break;
			if (t >= lim) return ST_DROPPED;
			tag_busy[t] = 1'b1;
			tgt_ip[t]   = bk_c[p].ip;
			tgt_port[t] = bk_c[p].port;
			held[t]     = c;
			if (bk_ping[p] < 2'd3) bk_ping[p]++;
			res.pv    = 1'b1;
			res.ptag  = t[0];
			res.pip   = bk_c[p].ip;
			res.pport = bk_c[p].port;
			return ST_PINGED;
		end
		return ST_DROPPED;
	endfunction

	function automatic outcome_t bucket_predict(cmd_t x);
		int n, p;
		contact_t h;
		logic [31:0] d;
		res = '{status: ST_NOTHING, default: '0};
		n = live_count();
		case (x.op)
			OP_INSERT: begin
				for (p = 0; p < n; p++) if (bk_c[p] == x.c) break;
				if (p < n) begin
					drop_pos(p);
					push_newest(x.c, x.now);
					last_chg = x.now;
					res.status = ST_REFRESHED;
				end else if (n < SLOTS) begin
					push_newest(x.c, x.now);
					last_chg = x.now;
					res.status = ST_ADDED;
				end else begin
					res.status = place_contact(x.c, x.now);
				end
			end
			OP_PING_RESP: begin
				last_chg = x.now;
				if (!tag_busy[x.tag]) begin
					res.status = ST_BAD_TAG;
				end else begin
					tag_busy[x.tag] = 1'b0;
					res.status = place_contact(held[x.tag], x.now);
				end
			end
			OP_PING_TIMEOUT: begin
				if (!tag_busy[x.tag]) begin
					res.status = ST_BAD_TAG;
				end else begin
					h = held[x.tag];
					for (p = 0; p < n; p++)
						if (bk_c[p].ip == tgt_ip[x.tag] && bk_c[p].port == tgt_port[x.tag]) break;
					if (p < n) begin
						drop_pos(p);
						push_newest(h, x.now);
						last_chg = x.now;
						res.status = ST_REPLACED;
					end
					tag_busy[x.tag] = 1'b0;
					if (busy_tags() < usable_tags() && wait_cnt > 0) begin
						h = waitq[wait_hd % QDEPTH];
						wait_hd = (wait_hd + 1) % QDEPTH;
						wait_cnt--;
						res.status = place_contact(h, x.now);
					end
				end
			end
			default: begin
				for (p = 0; p < n; p++) begin
					if (bk_c[p].ip == x.c.ip && bk_c[p].port == x.c.port) begin
						if (bk_fail[p] < 2'd3) bk_fail[p]++;
						res.found = 1'b1;
						break;
					end
				end
			end
		endcase
		n = live_count();
		d = x.now - last_chg;
		res.cnt = 4'(n);
		res.stale = (n > 0) && (d > m_stale);
		return res;
	endfunction

	// Driver: presents queued commands, holding each until the core takes it.
	always @(posedge clk or negedge arst_n) begin
		cmd_t nx;
		if (!arst_n) begin
			start     <= 1'b0;
			operation <= OP_INSERT;
			id_high   <= '0;
			id_middle <= '0;
			id_low    <= '0;
			ip_addr   <= '0;
			udp_port  <= '0;
			call_tag  <= 1'b0;
			now_ms    <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(bucket_predict('{operation,
					'{id_high, id_middle, id_low, ip_addr, udp_port}, call_tag, now_ms}));
				accepted++;
			end
			if (!start || !busy) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
					nx = pending_cmds[0];
					pending_cmds.delete(0);
					operation <= nx.op;
					id_high   <= nx.c.id_high;
					id_middle <= nx.c.id_middle;
					id_low    <= nx.c.id_low;
					ip_addr   <= nx.c.ip;
					udp_port  <= nx.c.port;
					call_tag  <= nx.tag;
					now_ms    <= nx.now;
					start     <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, act);
			err_count++;
		end
	endtask

	// Monitor and watchdog: each result beat is checked against the oldest prediction.
	int stall_cycles = 0;
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no command outstanding");
					err_count++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					check_field("status", 32'(e.status), 32'(status));
					check_field("ping_valid", 32'(e.pv), 32'(ping_valid));
					check_field("ping_tag", 32'(e.ptag), 32'(ping_tag));
					check_field("ping_ip", e.pip, ping_ip);
					check_field("ping_port", 32'(e.pport), 32'(ping_port));
					check_field("entry_count", 32'(e.cnt), 32'(entry_count));
					check_field("found_flag", 32'(e.found), 32'(found_flag));
					check_field("bucket_stale", 32'(e.stale), 32'(bucket_stale));
					if (e.pv) pings_seen++;
					checked++;
				end
			end
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Stimulus construction.
	contact_t pool [12];
	logic [31:0] clock_ms;
	logic [31:0] tick_span;

	function automatic contact_t rnd_contact();
		contact_t c;
		c.id_high   = {$urandom, $urandom};
		c.id_middle = {$urandom, $urandom};
		c.id_low    = $urandom;
		c.ip        = $urandom;
		c.port      = 16'($urandom);
		return c;
	endfunction

	task automatic add_cmd(logic [1:0] op, contact_t c, logic tag, logic [31:0] now);
		pending_cmds.push_back('{op, c, tag, now});
	endtask

	task automatic add_random_cmd();
		int r;
		contact_t c;
		r = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(0, tick_span);
		c = pool[$urandom_range(11)];
		// Occasionally a contact shares an id with a pool entry but not its port.
		if ($urandom_range(19) == 0) c.port = 16'($urandom);
		if (r < 50) add_cmd(OP_INSERT, c, 1'($urandom), clock_ms);
		else if (r < 55) add_cmd(OP_INSERT, rnd_contact(), 1'($urandom), clock_ms);
		else if (r < 68) add_cmd(OP_PING_RESP, rnd_contact(), 1'($urandom), clock_ms);
		else if (r < 80) add_cmd(OP_PING_TIMEOUT, rnd_contact(), 1'($urandom), clock_ms);
		else if (r < 95) add_cmd(OP_REQ_TIMEOUT, c, 1'($urandom), clock_ms);
		else add_cmd(OP_REQ_TIMEOUT, rnd_contact(), 1'($urandom), clock_ms);
	endtask

	task automatic write_regs(logic [31:0] w, logic [1:0] b, logic [1:0] s, logic [31:0] st);
		logic [31:0] vals [4];
		vals = '{w, {30'd0, b}, {30'd0, s}, st};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= 2'(i);
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		m_window = w;
		m_bad    = b;
		m_slots  = s;
		m_stale  = st;
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || expected_results.size() > 0 || start)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Register settings per phase; the first phase runs on the reset defaults.
	logic [31:0] ph_window [PHASES] = '{32'd900000, 32'd100, 32'd1, 32'hFFFFFFFF, 32'd50, 32'd300};
	logic [1:0]  ph_bad    [PHASES] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
	logic [1:0]  ph_slots  [PHASES] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
	logic [31:0] ph_stale  [PHASES] = '{32'd900000, 32'd1, 32'hFFFFFFFF, 32'd500, 32'd200, 32'd1000};

	initial begin
		contact_t z, o, c;
		for (int i = 0; i < SLOTS; i++) begin
			bk_valid[i] = 1'b0;
			bk_fail[i]  = 2'd0;
			bk_ping[i]  = 2'd0;
		end
		tag_busy = '{1'b0, 1'b0};
		wait_cnt = 0;
		wait_hd  = 0;
		last_chg = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: field extremes, idle tags, a full bucket, pings and the queue.
		z = '0;
		o = '1;
		add_cmd(OP_INSERT, z, 1'b0, 32'd0);
		add_cmd(OP_INSERT, o, 1'b1, 32'hFFFFFFFF);
		add_cmd(OP_INSERT, z, 1'b0, 32'd10);
		add_cmd(OP_PING_RESP, z, 1'b0, 32'd20);
		add_cmd(OP_PING_TIMEOUT, o, 1'b1, 32'd30);
		add_cmd(OP_REQ_TIMEOUT, o, 1'b0, 32'd40);
		add_cmd(OP_REQ_TIMEOUT, rnd_contact(), 1'b1, 32'd50);
		for (int i = 0; i < 6; i++) add_cmd(OP_INSERT, rnd_contact(), 1'b0, 32'd60 + i);
		for (int i = 0; i < 3; i++) add_cmd(OP_REQ_TIMEOUT, z, 1'b0, 32'd2000000);
		add_cmd(OP_INSERT, rnd_contact(), 1'b0, 32'd2000000);
		for (int i = 0; i < 7; i++) add_cmd(OP_INSERT, rnd_contact(), 1'b0, 32'd2000100);
		add_cmd(OP_PING_RESP, z, 1'b0, 32'd2000200);
		add_cmd(OP_PING_TIMEOUT, z, 1'b1, 32'd2000300);
		add_cmd(OP_PING_TIMEOUT, z, 1'b0, 32'd2000400);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				write_regs(ph_window[ph], ph_bad[ph], ph_slots[ph], ph_stale[ph]);
			end
			idle_pct = (ph < 2) ? 9 : (ph < 4) ? 46 : 0;
			for (int i = 0; i < 12; i++) pool[i] = rnd_contact();
			clock_ms = (ph == 0) ? 32'd3000000 : $urandom;
			tick_span = (m_window > 32'd4000) ? m_window / 4 : m_window / 2 + 2;
			for (int i = 0; i < PER_PHASE; i++) add_random_cmd();
		end
		drain();

		$display("Covered %0d commands over %0d register settings; %0d results checked.",
			accepted, PHASES, checked);
		$display("Pings issued: %0d; mismatches: %0d.", pings_seen, err_count);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
